### design/pcet_pkg.sv
// Shared types, codes and helpers for the periodic and countdown event table.
// No dependencies; every other design file imports this package.
package pcet_pkg;

    localparam int SLOT_COUNT_DEF = 20;
    localparam int QUEUE_DEPTH    = 4;

    // input op codes
    localparam logic [2:0] OP_START_PERIODIC  = 3'd0;
    localparam logic [2:0] OP_START_COUNTDOWN = 3'd1;
    localparam logic [2:0] OP_REMOVE          = 3'd2;
    localparam logic [2:0] OP_LENGTHEN        = 3'd3;
    localparam logic [2:0] OP_TICK            = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;
    localparam logic [1:0] KIND_MISSING = 2'd3;

    // slot classes
    localparam logic [1:0] CLASS_EMPTY  = 2'd0;
    localparam logic [1:0] CLASS_BEFORE = 2'd1;
    localparam logic [1:0] CLASS_AFTER  = 2'd2;

    localparam logic signed [15:0] PERIODIC_MARK = -16'sd1;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_REMOVE,
        CMD_LENGTHEN,
        CMD_TICK,
        CMD_NOP
    } t_cmd;

    // decoded command as queued between front and engine
    typedef struct packed {
        t_cmd               cmd;
        logic [7:0]         handler;
        logic [15:0]        argument;
        logic signed [15:0] turns;     // start time (-1 for periodic) or lengthen amount
        logic [1:0]         cls;
    } t_cmd_item;

    // one slot of the table memory
    typedef struct packed {
        logic [7:0]         handler;
        logic [15:0]        argument;
        logic signed [15:0] turns_left;
    } t_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_eng_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [1:0] phase_class(input logic phase);
        return phase ? CLASS_AFTER : CLASS_BEFORE;
    endfunction

    // signed 16-bit add, saturating at both ends
    function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic [16:0] s;
        s = {a[15], a} + {b[15], b};
        case (s[16:15])
            2'b01:   return 16'sh7fff;
            2'b10:   return 16'sh8000;
            default: return s[15:0];
        endcase
    endfunction

endpackage

### design/periodic_and_countdown_event_table_top.sv
// Top level of the periodic and countdown event table.
// Depends on pcet_pkg, pcet_front, pcet_cmd_queue and pcet_engine.
//
// Usage:
//  - Input channel (i_valid / o_stall): one command per beat. Ops are start
//    periodic, start countdown, remove, lengthen and tick; unused codes just
//    answer done.
//  - Output channel (o_valid / i_stall): result beats. A tick gives one fired
//    beat per periodic entry of its phase, then one per countdown entry that
//    reaches zero, then a done beat with o_last set. Every other command gives
//    exactly one beat with o_last set.
//  - Throughput: the engine scans one slot per cycle through the single read
//    port of the slot memory, except while a blocked result beat holds it. A tick
//    scans every slot in two passes; start, remove and lengthen stop at the
//    first matching slot. Unused ops skip the scan.
//  - A queue of QUEUE_DEPTH commands decouples input from the engine; o_stall
//    rises only when that queue is full.
//  - Receiver stall: the output register holds its beat; the scan keeps going
//    until it needs to place another beat, then freezes in place.
//  - Reset (synchronous, active low) empties every slot and the queue.
module periodic_and_countdown_event_table_top #(
    parameter int SLOT_COUNT = pcet_pkg::SLOT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_handler_id,
    input  logic signed [15:0] i_argument,
    input  logic signed [15:0] i_turns,
    input  logic               i_phase,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_fired_id,
    output logic signed [15:0] o_fired_argument,
    output logic               o_from_countdown,
    output logic               o_last
);
    import pcet_pkg::*;

    t_cmd_item     push_item, head_item;
    t_queue_status q_status;
    logic          push, pop;

    // decode ops into queue commands
    pcet_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_handler_id (i_handler_id),
        .i_argument   (i_argument),
        .i_turns      (i_turns),
        .i_phase      (i_phase),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_item       (push_item)
    );

    pcet_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    // slot table and scan sequencer
    pcet_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_head         (head_item),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_fired_id       (o_fired_id),
        .o_fired_argument (o_fired_argument),
        .o_from_countdown (o_from_countdown),
        .o_last           (o_last)
    );

endmodule

### design/pcet_front.sv
// Input side: takes items off the input channel and decodes them into queue commands.
// Depends on pcet_pkg.
module pcet_front (
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_op,
    input  logic [7:0]            i_handler_id,
    input  logic signed [15:0]    i_argument,
    input  logic signed [15:0]    i_turns,
    input  logic                  i_phase,
    input  pcet_pkg::t_queue_status i_q_status,
    output logic                  o_push,
    output pcet_pkg::t_cmd_item   o_item
);
    import pcet_pkg::*;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        o_item.handler  = i_handler_id;
        o_item.argument = i_argument;
        o_item.turns    = i_turns;
        o_item.cls      = phase_class(i_phase);
        case (i_op) inside
            OP_START_PERIODIC: begin
                o_item.cmd   = CMD_START;
                o_item.turns = PERIODIC_MARK;
            end
            OP_START_COUNTDOWN: o_item.cmd = CMD_START;
            OP_REMOVE:          o_item.cmd = CMD_REMOVE;
            OP_LENGTHEN:        o_item.cmd = CMD_LENGTHEN;
            OP_TICK:            o_item.cmd = CMD_TICK;
            default:            o_item.cmd = CMD_NOP;
        endcase
    end

endmodule

### design/pcet_cmd_queue.sv
// Short command queue between the front decoder and the table engine.
// Depends on pcet_pkg (command type, depth).
module pcet_cmd_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  pcet_pkg::t_cmd_item     i_item,
    input  logic                    i_pop,
    output pcet_pkg::t_cmd_item     o_head,
    output pcet_pkg::t_queue_status o_status
);
    import pcet_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd_item        r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_entry[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wr_ptr] <= i_item;
    end

endmodule

### design/pcet_engine.sv
// Table engine: slot memory, class flags, scan sequencer and output register.
// Depends on pcet_pkg.
module pcet_engine #(
    parameter int SLOT_COUNT = pcet_pkg::SLOT_COUNT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pcet_pkg::t_cmd_item     i_q_head,
    input  pcet_pkg::t_queue_status i_q_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_kind,
    output logic [7:0]              o_fired_id,
    output logic signed [15:0]      o_fired_argument,
    output logic                    o_from_countdown,
    output logic                    o_last
);
    import pcet_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // slot table: class flags in flops, payload in memory
    logic [1:0]  r_class [SLOT_COUNT];
    t_slot       r_mem   [SLOT_COUNT];
    t_slot       r_rd;

    t_eng_state  r_state, n_state;
    t_cmd_item   r_cmd;
    logic [1:0]  r_fin_kind, n_fin_kind;

    // read issue stage
    logic [IDX_W-1:0] r_ridx;
    logic             r_ipass;
    logic             r_idone;
    // evaluate stage
    logic             r_p2_valid;
    logic [IDX_W-1:0] r_p2_idx;
    logic             r_p2_pass;

    logic             r_o_valid;

    logic             emit, o_load, adv;
    logic [1:0]       e_kind;
    logic [7:0]       e_id;
    logic [15:0]      e_arg;
    logic             e_cd, e_last;
    logic             wr_en, cls_we;
    t_slot            wr_data;
    logic [1:0]       cls_val, cur_cls;
    logic             last_idx;

    assign o_load = emit && (!r_o_valid || !i_stall);
    assign adv    = !emit || o_load;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        n_fin_kind = r_fin_kind;
        o_pop      = 1'b0;
        emit       = 1'b0;
        e_kind     = KIND_DONE;
        e_id       = '0;
        e_arg      = '0;
        e_cd       = 1'b0;
        e_last     = 1'b0;
        wr_en      = 1'b0;
        wr_data    = r_rd;
        cls_we     = 1'b0;
        cls_val    = CLASS_EMPTY;
        cur_cls    = r_class[r_p2_idx];
        last_idx   = (r_p2_idx == IDX_W'(SLOT_COUNT - 1));
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop      = 1'b1;
                    n_fin_kind = KIND_DONE;
                    n_state    = (i_q_head.cmd == CMD_NOP) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_p2_valid) begin
                    case (r_cmd.cmd)
                        CMD_START: begin
                            if (cur_cls == CLASS_EMPTY) begin
                                wr_en      = 1'b1;
                                wr_data    = '{r_cmd.handler, r_cmd.argument, r_cmd.turns};
                                cls_we     = 1'b1;
                                cls_val    = r_cmd.cls;
                                n_fin_kind = KIND_DONE;
                                n_state    = S_FIN;
                            end else if (last_idx) begin
                                n_fin_kind = KIND_FULL;
                                n_state    = S_FIN;
                            end
                        end
                        CMD_REMOVE, CMD_LENGTHEN: begin
                            if (cur_cls != CLASS_EMPTY && r_rd.handler == r_cmd.handler) begin
                                if (r_cmd.cmd == CMD_REMOVE) begin
                                    cls_we = 1'b1;
                                end else begin
                                    wr_en = 1'b1;
                                    wr_data.turns_left = sat_add16(r_rd.turns_left, r_cmd.turns);
                                end
                                n_fin_kind = KIND_DONE;
                                n_state    = S_FIN;
                            end else if (last_idx) begin
                                n_fin_kind = KIND_MISSING;
                                n_state    = S_FIN;
                            end
                        end
                        CMD_TICK: begin
                            if (cur_cls == r_cmd.cls) begin
                                if (!r_p2_pass) begin
                                    if (r_rd.turns_left == PERIODIC_MARK) begin
                                        emit   = 1'b1;
                                        e_kind = KIND_FIRED;
                                        e_id   = r_rd.handler;
                                        e_arg  = r_rd.argument;
                                    end
                                end else if (r_rd.turns_left > 16'sd0) begin
                                    wr_en = 1'b1;
                                    wr_data.turns_left = r_rd.turns_left - 16'sd1;
                                    if (r_rd.turns_left == 16'sd1) begin
                                        cls_we = 1'b1;
                                        emit   = 1'b1;
                                        e_kind = KIND_FIRED;
                                        e_id   = r_rd.handler;
                                        e_arg  = r_rd.argument;
                                        e_cd   = 1'b1;
                                    end
                                end
                            end
                            if (last_idx && r_p2_pass) begin
                                n_fin_kind = KIND_DONE;
                                n_state    = S_FIN;
                            end
                        end
                        default: begin
                            n_fin_kind = KIND_DONE;
                            n_state    = S_FIN;
                        end
                    endcase
                end
            end
            S_FIN: begin
                emit   = 1'b1;
                e_kind = r_fin_kind;
                e_last = 1'b1;
                if (o_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // a blocked fired result freezes the scan
        if (r_state == S_SCAN && !adv) begin
            n_state    = r_state;
            n_fin_kind = r_fin_kind;
        end
    end

    // control registers of the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_kind <= KIND_DONE;
            r_ridx     <= '0;
            r_ipass    <= 1'b0;
            r_idone    <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p2_idx   <= '0;
            r_p2_pass  <= 1'b0;
            for (int k = 0; k < SLOT_COUNT; k++) r_class[k] <= CLASS_EMPTY;
        end else begin
            r_fin_kind <= n_fin_kind;
            case (r_state)
                S_IDLE: begin
                    r_ridx     <= '0;
                    r_ipass    <= 1'b0;
                    r_idone    <= 1'b0;
                    r_p2_valid <= 1'b0;
                end
                S_SCAN: begin
                    if (adv) begin
                        if (cls_we) r_class[r_p2_idx] <= cls_val;
                        r_p2_valid <= !r_idone && (n_state == S_SCAN);
                        r_p2_idx   <= r_ridx;
                        r_p2_pass  <= r_ipass;
                        if (!r_idone) begin
                            if (r_ridx == IDX_W'(SLOT_COUNT - 1)) begin
                                r_ridx <= '0;
                                if (r_ipass || r_cmd.cmd != CMD_TICK) r_idone <= 1'b1;
                                else                                 r_ipass <= 1'b1;
                            end else begin
                                r_ridx <= r_ridx + 1'b1;
                            end
                        end
                    end
                end
                default: r_p2_valid <= 1'b0;
            endcase
        end
    end

    // command register, table memory port and its registered read
    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_q_head;
        if (r_state == S_SCAN && adv) begin
            if (!r_idone) r_rd <= r_mem[r_ridx];
            if (wr_en)    r_mem[r_p2_idx] <= wr_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_o_valid <= 1'b0;
        else if (o_load)   r_o_valid <= 1'b1;
        else if (!i_stall) r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            o_kind           <= e_kind;
            o_fired_id       <= e_id;
            o_fired_argument <= e_arg;
            o_from_countdown <= e_cd;
            o_last           <= e_last;
        end
    end

endmodule

### tb/tb_top.sv
// Self-checking bench for periodic_and_countdown_event_table_top: a slot table
// predictor checks every result beat of a directed and a random command run.
// Depends on pcet_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_top;
    import pcet_pkg::*;

    localparam int SLOT_COUNT = SLOT_COUNT_DEF;

    // op codes the block does not use; each just answers done
    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;

    localparam int RANDOM_ITEMS = 386;  // counted random commands after the directed part
    localparam int IDLE_PCT     = 20;
    // sender inserts no random idle gaps while the accepted count is in this window
    localparam int SEND_BUSY_LO = 180;
    localparam int SEND_BUSY_HI = 260;
    // receiver never stalls while the result count is in this window
    localparam int RECV_BUSY_LO = 300;
    localparam int RECV_BUSY_HI = 450;
    // one long receiver hold-off; the command queue fills and o_stall rises
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 2 * SLOT_COUNT + 10;

    // one command beat, plus a flag that makes the sender wait for a drained pipe
    typedef struct {
        logic [2:0]  op;
        logic [7:0]  hid;
        logic [15:0] arg;
        logic [15:0] turns;
        logic        phase;
        bit          drain_first;
    } t_cmd_beat;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [15:0] arg;
        logic        cd;
        logic        last;
    } t_event_beat;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic [2:0]         i_op             = '0;
    logic [7:0]         i_handler_id     = '0;
    logic signed [15:0] i_argument       = '0;
    logic signed [15:0] i_turns          = '0;
    logic               i_phase          = 1'b0;
    logic               i_stall          = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_kind;
    logic [7:0]         o_fired_id;
    logic signed [15:0] o_fired_argument;
    logic               o_from_countdown;
    logic               o_last;

    periodic_and_countdown_event_table_top #(
        .SLOT_COUNT(SLOT_COUNT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_handler_id    (i_handler_id),
        .i_argument      (i_argument),
        .i_turns         (i_turns),
        .i_phase         (i_phase),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_fired_id      (o_fired_id),
        .o_fired_argument(o_fired_argument),
        .o_from_countdown(o_from_countdown),
        .o_last          (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predicted slot table. Time is kept as int so saturation is explicit.
    // ------------------------------------------------------------------
    logic [1:0]  tbl_class [SLOT_COUNT];
    logic [7:0]  tbl_hid   [SLOT_COUNT];
    logic [15:0] tbl_arg   [SLOT_COUNT];
    int          tbl_time  [SLOT_COUNT];

    t_cmd_beat   pending[$];         // commands not yet offered
    t_event_beat expected_beats[$];  // predicted result beats, oldest first

    int n_accepted  = 0;
    int n_results   = 0;
    int n_mismatch  = 0;
    bit in_taken    = 1'b0;  // a command beat went in at the last rising edge
    bit send_gap;
    t_cmd_beat next_cmd;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_class[i] = CLASS_EMPTY;
            tbl_hid[i]   = '0;
            tbl_arg[i]   = '0;
            tbl_time[i]  = 0;
        end
    end

    function automatic void expect_beat(input logic [1:0] kind, input logic [7:0] id,
                                        input logic [15:0] arg, input logic cd,
                                        input logic last);
        t_event_beat b;
        b.kind = kind;
        b.id   = id;
        b.arg  = arg;
        b.cd   = cd;
        b.last = last;
        expected_beats.push_back(b);
    endfunction

    // Apply one accepted command to the table and queue the beats it produces.
    function automatic void predict_event_cmd(input logic [2:0] op, input logic [7:0] hid,
                                              input logic [15:0] arg,
                                              input logic signed [15:0] turns,
                                              input logic phase);
        int         slot;
        int         sum;
        logic [1:0] cls;
        cls  = phase ? CLASS_AFTER : CLASS_BEFORE;
        slot = -1;
        case (op)
            OP_START_PERIODIC, OP_START_COUNTDOWN: begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (slot < 0 && tbl_class[i] == CLASS_EMPTY)
                        slot = i;
                if (slot < 0) begin
                    expect_beat(KIND_FULL, '0, '0, 1'b0, 1'b1);
                end else begin
                    tbl_class[slot] = cls;
                    tbl_hid[slot]   = hid;
                    tbl_arg[slot]   = arg;
                    tbl_time[slot]  = (op == OP_START_PERIODIC) ? -1 : int'(turns);
                    expect_beat(KIND_DONE, '0, '0, 1'b0, 1'b1);
                end
            end
            OP_REMOVE, OP_LENGTHEN: begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (slot < 0 && tbl_class[i] != CLASS_EMPTY && tbl_hid[i] == hid)
                        slot = i;
                if (slot < 0) begin
                    expect_beat(KIND_MISSING, '0, '0, 1'b0, 1'b1);
                end else begin
                    if (op == OP_REMOVE) begin
                        tbl_class[slot] = CLASS_EMPTY;
                    end else begin
                        sum = tbl_time[slot] + int'(turns);
                        if (sum > 32767)
                            sum = 32767;
                        if (sum < -32768)
                            sum = -32768;
                        tbl_time[slot] = sum;
                    end
                    expect_beat(KIND_DONE, '0, '0, 1'b0, 1'b1);
                end
            end
            OP_TICK: begin
                // periodic entries of this phase first, then the countdowns
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (tbl_class[i] == cls && tbl_time[i] == -1)
                        expect_beat(KIND_FIRED, tbl_hid[i], tbl_arg[i], 1'b0, 1'b0);
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (tbl_class[i] == cls && tbl_time[i] > 0) begin
                        tbl_time[i] = tbl_time[i] - 1;
                        if (tbl_time[i] == 0) begin
                            tbl_class[i] = CLASS_EMPTY;
                            expect_beat(KIND_FIRED, tbl_hid[i], tbl_arg[i], 1'b1, 1'b0);
                        end
                    end
                end
                expect_beat(KIND_DONE, '0, '0, 1'b0, 1'b1);
            end
            default: begin
                expect_beat(KIND_DONE, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    task automatic note_mismatch(input string what, input t_event_beat want);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $write("%0t %s: expected kind=%0d id=%02h arg=%04h cd=%0d last=%0d",
                   $time, what, want.kind, want.id, want.arg, want.cd, want.last);
            $display(" got kind=%0d id=%02h arg=%04h cd=%0d last=%0d",
                     o_kind, o_fired_id, o_fired_argument, o_from_countdown, o_last);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: checks result beats, then predicts from command beats.
    // Results trail acceptance, so one block handles both.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_event_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_beats.size() == 0) begin
                want = '0;
                note_mismatch("result beat with nothing expected", want);
            end else begin
                want = expected_beats.pop_front();
                if (o_kind !== want.kind || o_fired_id !== want.id ||
                    o_fired_argument !== want.arg || o_from_countdown !== want.cd ||
                    o_last !== want.last)
                    note_mismatch("result beat mismatch", want);
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            predict_event_cmd(i_op, i_handler_id, i_argument, i_turns, i_phase);
            n_accepted++;
        end
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    // ------------------------------------------------------------------
    // Command driver: new beat at the falling edge once the old one went in.
    // Valid is held until acceptance regardless of o_stall. A beat tagged
    // drain_first is held back until every predicted result has arrived.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        send_gap = (n_accepted < SEND_BUSY_LO || n_accepted >= SEND_BUSY_HI) &&
                   ($urandom_range(0, 99) < IDLE_PCT);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending.size() != 0 && !send_gap &&
                !(pending[0].drain_first && expected_beats.size() != 0)) begin
                next_cmd = pending.pop_front();
                i_op         <= next_cmd.op;
                i_handler_id <= next_cmd.hid;
                i_argument   <= next_cmd.arg;
                i_turns      <= next_cmd.turns;
                i_phase      <= next_cmd.phase;
                i_valid      <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, a busy window with none, and one long
    // hold-off counted here so the engine and the command queue back up.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (n_results >= RECV_BUSY_LO && n_results < RECV_BUSY_HI) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic [2:0] op, input logic [7:0] hid,
                             input logic [15:0] arg, input logic [15:0] turns,
                             input logic phase, input bit drain);
        t_cmd_beat c;
        c.op          = op;
        c.hid         = hid;
        c.arg         = arg;
        c.turns       = turns;
        c.phase       = phase;
        c.drain_first = drain;
        pending.push_back(c);
    endtask

    // small id pool so remove and lengthen usually hit a live slot
    function automatic logic [7:0] pick_handler();
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(0, 11));
        return 8'($urandom());
    endfunction

    // mostly short countdowns that fire soon; also zero, minus one, negatives, wide
    function automatic logic [15:0] pick_countdown();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(1, 6));
        if (r < 76)
            return 16'h0000;
        if (r < 82)
            return 16'hFFFF;
        if (r < 90)
            return 16'(-int'($urandom_range(2, 32768)));
        return 16'($urandom());
    endfunction

    initial begin
        int          n_real;
        int          r;
        logic [2:0]  op;
        logic [15:0] step;
        bit          drain;

        // --- directed part ---
        // both lookups miss on an empty table
        queue_cmd(OP_REMOVE,          8'hFF, 16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_cmd(OP_LENGTHEN,        8'h00, 16'h0000, 16'h0001, 1'b1, 1'b0);
        // periodic entries at the argument extremes, one per phase
        queue_cmd(OP_START_PERIODIC,  8'h00, 16'h8000, 16'h0005, 1'b0, 1'b0);
        queue_cmd(OP_START_PERIODIC,  8'hFF, 16'h7FFF, 16'h0000, 1'b1, 1'b0);
        // countdowns: one tick, zero, minus one (acts periodic), both time extremes
        queue_cmd(OP_START_COUNTDOWN, 8'h11, 16'hFFFF, 16'h0001, 1'b0, 1'b0);
        queue_cmd(OP_START_COUNTDOWN, 8'h22, 16'h1234, 16'h0000, 1'b0, 1'b0);
        queue_cmd(OP_START_COUNTDOWN, 8'h33, 16'hA5A5, 16'hFFFF, 1'b1, 1'b0);
        queue_cmd(OP_START_COUNTDOWN, 8'h44, 16'h5A5A, 16'h8000, 1'b0, 1'b0);
        queue_cmd(OP_START_COUNTDOWN, 8'h55, 16'h0001, 16'h7FFF, 1'b1, 1'b0);
        queue_cmd(OP_TICK,            8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_cmd(OP_TICK,            8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        // saturate high and low, turn a periodic entry into a countdown
        queue_cmd(OP_LENGTHEN,        8'h55, 16'h0000, 16'h7FFF, 1'b0, 1'b0);
        queue_cmd(OP_LENGTHEN,        8'h44, 16'h0000, 16'h8000, 1'b0, 1'b0);
        queue_cmd(OP_LENGTHEN,        8'h00, 16'h0000, 16'h0003, 1'b0, 1'b0);
        queue_cmd(OP_LENGTHEN,        8'h22, 16'h0000, 16'h0002, 1'b0, 1'b0);
        queue_cmd(OP_RSVD_A,          8'h5A, 16'h1111, 16'h2222, 1'b0, 1'b0);
        queue_cmd(OP_RSVD_B,          8'hA5, 16'h3333, 16'h4444, 1'b1, 1'b0);
        queue_cmd(OP_RSVD_C,          8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        queue_cmd(OP_TICK,            8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
        // lengthen to exactly minus one: the entry becomes periodic
        queue_cmd(OP_LENGTHEN,        8'h22, 16'h0000, 16'hFFFE, 1'b0, 1'b0);
        queue_cmd(OP_TICK,            8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_cmd(OP_REMOVE,          8'h33, 16'h0000, 16'h0000, 1'b1, 1'b0);
        queue_cmd(OP_REMOVE,          8'h33, 16'h0000, 16'h0000, 1'b1, 1'b0);
        queue_cmd(OP_TICK,            8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0);

        // --- random part ---
        // Occasional bursts of starts overrun the table to hit the full answer;
        // the first one comes right away. Unused ops count as items too.
        n_real = 0;
        while (n_real < RANDOM_ITEMS) begin
            r     = $urandom_range(0, 99);
            drain = (n_real == 0) || ($urandom_range(0, 99) < 2);
            if (n_real == 0 || r == 0) begin
                for (int k = 0; k < SLOT_COUNT + 2; k++) begin
                    op = ($urandom_range(0, 99) < 85) ? OP_START_COUNTDOWN : OP_START_PERIODIC;
                    queue_cmd(op, pick_handler(), 16'($urandom()), pick_countdown(),
                              1'($urandom()), drain && k == 0);
                    n_real++;
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    op = OP_START_PERIODIC;
                else if (r < 35)
                    op = OP_START_COUNTDOWN;
                else if (r < 47)
                    op = OP_REMOVE;
                else if (r < 60)
                    op = OP_LENGTHEN;
                else if (r < 95)
                    op = OP_TICK;
                else
                    op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
                if (op == OP_LENGTHEN) begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        step = 16'(int'($urandom_range(0, 8)) - 4);
                    else if (r < 70)
                        step = 16'h7FFF;
                    else if (r < 80)
                        step = 16'h8000;
                    else
                        step = 16'($urandom());
                end else begin
                    step = pick_countdown();
                end
                queue_cmd(op, pick_handler(), 16'($urandom()), step, 1'($urandom()), drain);
                n_real++;
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // everything offered and accepted, every predicted beat seen
        while (pending.size() != 0 || i_valid || expected_beats.size() != 0)
            @(negedge i_clk);
        // a stray extra beat would show up within a tick's length
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (n_mismatch == 0 && expected_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
design/pcet_pkg.sv
design/pcet_front.sv
design/pcet_cmd_queue.sv
design/pcet_engine.sv
design/periodic_and_countdown_event_table_top.sv
tb/tb_top.sv
